[src/kvl_pkg.sv]
// Shared constants and types of the key-value lookup block.
package kvl_pkg;

  // Limits of the scan.
  localparam logic [4:0] MAX_KEY_BYTES    = 5'd16;
  localparam logic [7:0] MAX_BUFFER_BYTES = 8'd255;

  // Saturation value of the key byte counter.
  localparam logic [4:0] KEY_COUNT_MAX = 5'd31;

  // Delimiter bytes.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

  // Result kinds.
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Scan phase, one-hot.
  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_KEY   = 5'b00010,
    PH_SKIP  = 5'b00100,
    PH_VALUE = 5'b01000,
    PH_FOUND = 5'b10000
  } kvl_phase_e;

  // One result item.
  typedef struct packed {
    logic       result_kind;
    logic [7:0] value_byte;
    logic       found;
    logic [7:0] value_length;
    logic       run_end;
  } kvl_result_t;

  // Results caused by one scanned byte: an optional value byte, then an
  // optional status.
  typedef struct packed {
    logic        val_v;
    kvl_result_t val_res;
    logic        sts_v;
    kvl_result_t sts_res;
  } kvl_scan_out_t;

endpackage

[src/kvl_scan.sv]
// Scanner that tracks the key/value phase of the stream and forms results.
module kvl_scan import kvl_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     text_byte_i,
  input  logic           final_byte_i,
  input  logic [127:0]   key_chars_i,
  input  logic [4:0]     key_length_i,
  output kvl_scan_out_t  out_o
);

  kvl_phase_e phase_q, phase_d, phase_n;
  logic [4:0] kcount_q, kcount_d, kcount_n;
  logic       mismatch_q, mismatch_d, mismatch_n;
  logic [7:0] vcount_q, vcount_d, vcount_n;
  logic [7:0] key_byte;
  logic       hit;
  logic       val_v;
  logic       found;

  // Configured key byte at the current key position.
  assign key_byte = key_chars_i[{kcount_q[3:0], 3'b000} +: 8];

  // The key matches when every byte agreed and the length is exact.
  assign hit = !mismatch_q && (key_length_i != 5'd0) &&
               (key_length_i <= MAX_KEY_BYTES) && (kcount_q == key_length_i);

  // Phase update for one byte.
  always_comb begin
    phase_n    = phase_q;
    kcount_n   = kcount_q;
    mismatch_n = mismatch_q;
    vcount_n   = vcount_q;
    val_v      = 1'b0;
    case (phase_q)
      PH_START: begin
        // The first byte stands for the leading comma.
        phase_n    = PH_KEY;
        kcount_n   = 5'd0;
        mismatch_n = 1'b0;
        vcount_n   = 8'd0;
      end
      PH_KEY: begin
        if (text_byte_i == CH_COLON) begin
          phase_n  = hit ? PH_VALUE : PH_SKIP;
          vcount_n = 8'd0;
        end else begin
          if ((kcount_q < key_length_i) && (kcount_q < MAX_KEY_BYTES)) begin
            if (key_byte != text_byte_i) begin
              mismatch_n = 1'b1;
            end
          end else begin
            mismatch_n = 1'b1;
          end
          if (kcount_q != KEY_COUNT_MAX) begin
            kcount_n = kcount_q + 5'd1;
          end
        end
      end
      PH_SKIP: begin
        if (text_byte_i == CH_COMMA) begin
          phase_n    = PH_KEY;
          kcount_n   = 5'd0;
          mismatch_n = 1'b0;
        end
      end
      PH_VALUE: begin
        if (text_byte_i == CH_COMMA) begin
          phase_n = PH_FOUND;
        end else if (vcount_q < MAX_BUFFER_BYTES) begin
          vcount_n = vcount_q + 8'd1;
          val_v    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // The final byte closes the buffer and returns the scan to its start.
  assign found = (phase_n == PH_FOUND);

  always_comb begin
    if (final_byte_i) begin
      phase_d    = PH_START;
      kcount_d   = 5'd0;
      mismatch_d = 1'b0;
      vcount_d   = 8'd0;
    end else begin
      phase_d    = phase_n;
      kcount_d   = kcount_n;
      mismatch_d = mismatch_n;
      vcount_d   = vcount_n;
    end
  end

  // Result items of this byte.
  always_comb begin
    out_o.val_v                = val_v;
    out_o.val_res.result_kind  = KIND_VALUE;
    out_o.val_res.value_byte   = text_byte_i;
    out_o.val_res.found        = 1'b0;
    out_o.val_res.value_length = 8'd0;
    out_o.val_res.run_end      = 1'b0;
    out_o.sts_v                = final_byte_i;
    out_o.sts_res.result_kind  = KIND_STATUS;
    out_o.sts_res.value_byte   = 8'd0;
    out_o.sts_res.found        = found;
    out_o.sts_res.value_length = found ? vcount_n : 8'd0;
    out_o.sts_res.run_end      = 1'b1;
  end

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      kcount_q   <= 5'd0;
      mismatch_q <= 1'b0;
      vcount_q   <= 8'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      kcount_q   <= kcount_d;
      mismatch_q <= mismatch_d;
      vcount_q   <= vcount_d;
    end
  end

endmodule

[src/key_value_lookup.sv]
// Top level of the key-value lookup: input register, scanner and result queue.
//
//   channel   signals                                   direction
//   in        in_valid_i / in_ready_o, text, final      byte stream in
//   out       out_valid_o / out_ready_i, result fields  value bytes and status
//   cfg       cfg_we_i, cfg_addr_i, cfg_wdata_i         key registers
//
// One byte is accepted per cycle while in_ready_o is high. A byte is held in
// the input register, and the scanner writes its results into a four-entry
// queue. The queue sends one result per cycle while out_ready_i is high, so a
// byte that yields both a value byte and the status fills two entries. Reset
// clears the scan and the queue; the key registers reset to zero. A stalled
// output backs up into the input register when fewer than two entries are free.
module key_value_lookup import kvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  value_byte_o,
  output logic        found_o,
  output logic [7:0]  value_length_o,
  output logic        run_end_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i
);

  logic [63:0]   key_low_q, key_high_q;
  logic [4:0]    key_length_q;
  logic          stage_v_q;
  logic [7:0]    stage_byte_q;
  logic          stage_final_q;
  logic          stage_go;
  logic          in_take;
  logic          pop;
  logic [2:0]    free;
  kvl_scan_out_t scan;
  kvl_result_t   queue_q [4];
  logic [1:0]    wr_q, rd_q;
  logic [2:0]    cnt_q;
  logic [1:0]    push_n;
  kvl_result_t   head;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q    <= 64'd0;
      key_high_q   <= 64'd0;
      key_length_q <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_KEY_LOW:    key_low_q    <= cfg_wdata_i;
        REG_KEY_HIGH:   key_high_q   <= cfg_wdata_i;
        REG_KEY_LENGTH: key_length_q <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake bookkeeping.
  assign pop        = out_valid_o && out_ready_i;
  assign free       = (3'd4 - cnt_q) + {2'd0, pop};
  assign stage_go   = stage_v_q && (free >= 3'd2);
  assign in_ready_o = !stage_v_q || stage_go;
  assign in_take    = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stage_byte_q  <= text_byte_i;
      stage_final_q <= final_byte_i;
    end
  end

  // Scanner on the registered byte.
  kvl_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (stage_go),
    .text_byte_i  (stage_byte_q),
    .final_byte_i (stage_final_q),
    .key_chars_i  ({key_high_q, key_low_q}),
    .key_length_i (key_length_q),
    .out_o        (scan)
  );

  assign push_n = stage_go ? ({1'b0, scan.val_v} + {1'b0, scan.sts_v}) : 2'd0;

  // Result queue storage; the value byte goes ahead of the status.
  always_ff @(posedge clk_i) begin
    if (stage_go) begin
      if (scan.val_v) begin
        queue_q[wr_q] <= scan.val_res;
        if (scan.sts_v) begin
          queue_q[wr_q + 2'd1] <= scan.sts_res;
        end
      end else if (scan.sts_v) begin
        queue_q[wr_q] <= scan.sts_res;
      end
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_q + push_n;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, push_n} - {2'd0, pop};
    end
  end

  // Output fields from the queue head.
  assign head           = queue_q[rd_q];
  assign out_valid_o    = (cnt_q != 3'd0);
  assign result_kind_o  = head.result_kind;
  assign value_byte_o   = head.value_byte;
  assign found_o        = head.found;
  assign value_length_o = head.value_length;
  assign run_end_o      = head.run_end;

endmodule
